// ===== sv/rmt_pkg.sv =====
// Shared types and constants of the running median tracker.
// Used by rmt_cell, rmt_chain and running_median_tracker; depends on nothing.
package rmt_pkg;

    // Default sizing
    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths on the stream ports
    localparam int SAMPLE_W  = 16;
    localparam int MEDIAN_W  = 16;
    localparam int COUNT_W   = 11;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    // Operation broadcast to every cell of a chain at once
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT,
        OP_PUSH,
        OP_POP
    } cell_op_t;

    // Control handed from the sequencer to one chain
    typedef struct packed {
        cell_op_t op;
    } chain_ctrl_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INSERT,
        ST_BALANCE,
        ST_EMIT
    } seq_state_t;

endpackage

// ===== sv/running_median_tracker.sv =====
// Running lower median over a stream of signed values, two sorted cell rows.
// Depends on rmt_pkg, rmt_chain and rmt_cell.
//
//  channel | dir | fields (low bit first)                               | accepted when
//  s_*     | in  | tdata: sample_value[15:0]; tuser: restart            | s_tvalid & s_tready
//  m_*     | out | tdata: median_value[15:0], held_count[26:16], zeros; | m_tvalid & m_tready
//          |     | tuser: dropped                                       |
//
// From accept to result register, a request is inserted into one row, the two
// rows are rebalanced and the result is loaded (a restart first clears both rows;
// a full store drops the value and skips the rebalance). The next request can be
// accepted in the cycle after the result load.
// A new request is taken while the previous result still waits on m_tready;
// the result load of that request then waits for the output register to free.
// Reset empties both rows at once through the occupied flags; no sweep.
module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // sample_value[15:0]
    input  logic                  s_tuser,   // restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // median_value[15:0], held_count[26:16]
    output logic                  m_tuser    // dropped
);

    localparam int HALF = CAPACITY / 2 + 1;
    localparam int CW   = $clog2(CAPACITY + 1);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic signed [VALUE_WIDTH-1:0] x_reg;
    logic signed [VALUE_WIDTH-1:0] x_next;
    logic                          drop_reg;
    logic                          drop_next;
    logic [CW-1:0]                 lo_cnt_reg;
    logic [CW-1:0]                 lo_cnt_next;
    logic [CW-1:0]                 up_cnt_reg;
    logic [CW-1:0]                 up_cnt_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [MEDIAN_W-1:0]           out_median_reg;
    logic [MEDIAN_W-1:0]           out_median_next;
    logic [COUNT_W-1:0]            out_count_reg;
    logic [COUNT_W-1:0]            out_count_next;
    logic                          out_drop_reg;
    logic                          out_drop_next;

    logic signed [VALUE_WIDTH-1:0] sample_ext;
    logic                          in_fire;
    logic                          out_free;
    logic [CW:0]                   total;
    logic                          full;
    logic                          to_lower;
    logic                          lo_heavy;
    logic                          up_heavy;

    chain_ctrl_t                   lo_ctrl;
    chain_ctrl_t                   up_ctrl;
    logic signed [VALUE_WIDTH-1:0] lo_x;
    logic signed [VALUE_WIDTH-1:0] up_x;
    logic signed [VALUE_WIDTH-1:0] lo_front;
    logic signed [VALUE_WIDTH-1:0] up_front;
    logic                          lo_front_occ;
    logic                          up_front_occ;

    // Read the sample at the store width
    assign sample_ext = VALUE_WIDTH'(s_tdata[SAMPLE_W-1:0]);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign total    = (CW + 1)'(lo_cnt_reg) + (CW + 1)'(up_cnt_reg);
    assign full     = (total >= (CW + 1)'(CAPACITY));
    assign to_lower = (lo_cnt_reg == '0) || (x_reg <= lo_front);
    assign lo_heavy = ((CW + 1)'(lo_cnt_reg) > (CW + 1)'(up_cnt_reg) + (CW + 1)'(1));
    assign up_heavy = (up_cnt_reg > lo_cnt_reg);

    // Lower half, largest value in front: its front is the lower median
    rmt_chain #(
        .DEPTH       (HALF),
        .VALUE_WIDTH (VALUE_WIDTH),
        .DESCEND     (1'b1)
    ) u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lo_ctrl),
        .x         (lo_x),
        .front_val (lo_front),
        .front_occ (lo_front_occ)
    );

    // Upper half, smallest value in front
    rmt_chain #(
        .DEPTH       (HALF),
        .VALUE_WIDTH (VALUE_WIDTH),
        .DESCEND     (1'b0)
    ) u_upper (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (up_ctrl),
        .x         (up_x),
        .front_val (up_front),
        .front_occ (up_front_occ)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = s_tuser ? ST_CLEAR : ST_INSERT;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = full ? ST_EMIT : ST_BALANCE;
            end
            ST_BALANCE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Row operations, counts and result load
    always_comb
    begin
        x_next          = x_reg;
        drop_next       = drop_reg;
        lo_cnt_next     = lo_cnt_reg;
        up_cnt_next     = up_cnt_reg;
        lo_ctrl.op      = OP_HOLD;
        up_ctrl.op      = OP_HOLD;
        lo_x            = x_reg;
        up_x            = x_reg;
        out_valid_next  = out_valid_reg;
        out_median_next = out_median_reg;
        out_count_next  = out_count_reg;
        out_drop_next   = out_drop_reg;

        // Drop the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next = sample_ext;
                end
            end
            ST_CLEAR:
            begin
                lo_ctrl.op  = OP_CLEAR;
                up_ctrl.op  = OP_CLEAR;
                lo_cnt_next = '0;
                up_cnt_next = '0;
            end
            ST_INSERT:
            begin
                drop_next = full;
                if (!full)
                begin
                    if (to_lower)
                    begin
                        lo_ctrl.op  = OP_INSERT;
                        lo_cnt_next = lo_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        up_ctrl.op  = OP_INSERT;
                        up_cnt_next = up_cnt_reg + CW'(1);
                    end
                end
            end
            ST_BALANCE:
            begin
                // Move one front value across so the lower half keeps the median
                if (lo_heavy)
                begin
                    lo_ctrl.op  = OP_POP;
                    up_ctrl.op  = OP_PUSH;
                    up_x        = lo_front;
                    lo_cnt_next = lo_cnt_reg - CW'(1);
                    up_cnt_next = up_cnt_reg + CW'(1);
                end
                else if (up_heavy)
                begin
                    up_ctrl.op  = OP_POP;
                    lo_ctrl.op  = OP_PUSH;
                    lo_x        = up_front;
                    up_cnt_next = up_cnt_reg - CW'(1);
                    lo_cnt_next = lo_cnt_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_median_next = MEDIAN_W'(lo_front);
                    out_count_next  = COUNT_W'(total);
                    out_drop_next   = drop_reg;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lo_cnt_reg    <= '0;
            up_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_cnt_reg    <= lo_cnt_next;
            up_cnt_reg    <= up_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        drop_reg       <= drop_next;
        out_median_reg <= out_median_next;
        out_count_reg  <= out_count_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_count_reg, out_median_reg});
    assign m_tuser  = out_drop_reg;

`ifndef SYNTHESIS
    // Halves stay balanced between requests
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ((lo_cnt_reg == up_cnt_reg) || (lo_cnt_reg == up_cnt_reg + CW'(1))))
        else $error("median halves out of balance");

    // Never hold more than the capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CW + 1)'(CAPACITY))
        else $error("held count above capacity");

    // Front occupied flags agree with the counts
    a_front_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ((lo_front_occ == (lo_cnt_reg != '0)) && (up_front_occ == (up_cnt_reg != '0))))
        else $error("front cell flag disagrees with count");

    // A dropped request only comes from a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free && drop_reg) |-> full)
        else $error("drop flagged with room left");

    // Every result reports at least one held value
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |-> (lo_cnt_reg != '0))
        else $error("result loaded from an empty store");
`endif

endmodule

// ===== sv/rmt_cell.sv =====
// One storage cell of a sorted chain: holds one value and its occupied flag.
// Depends on rmt_pkg; talks only to its two neighbors and the broadcast bus.
module rmt_cell
    import rmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter bit DESCEND     = 1'b0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chain_ctrl_t                   ctrl,
    input  logic signed [VALUE_WIDTH-1:0] x,
    input  logic signed [VALUE_WIDTH-1:0] prev_val,
    input  logic                          prev_occ,
    input  logic                          prev_ahead,
    input  logic signed [VALUE_WIDTH-1:0] next_val,
    input  logic                          next_occ,
    output logic signed [VALUE_WIDTH-1:0] val,
    output logic                          occ,
    output logic                          ahead
);

    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic signed [VALUE_WIDTH-1:0] val_next;
    logic                          occ_reg;
    logic                          occ_next;
    logic                          cmp;

    // Held value stays in front of the new one (equal values stay in front)
    assign cmp   = DESCEND ? (val_reg >= x) : (val_reg <= x);
    assign ahead = occ_reg & cmp;

    // Pick next contents from the broadcast operation
    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        case (ctrl.op)
            OP_HOLD:
            begin
                val_next = val_reg;
                occ_next = occ_reg;
            end
            OP_CLEAR:
            begin
                occ_next = 1'b0;
            end
            OP_INSERT:
            begin
                if (!ahead)
                begin
                    val_next = prev_ahead ? x : prev_val;
                end
                occ_next = occ_reg | prev_occ;
            end
            OP_PUSH:
            begin
                val_next = prev_val;
                occ_next = prev_occ;
            end
            OP_POP:
            begin
                val_next = next_val;
                occ_next = next_occ;
            end
            default:
            begin
                val_next = val_reg;
                occ_next = occ_reg;
            end
        endcase
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

// ===== sv/rmt_chain.sv =====
// Row of rmt_cell instances kept in sorted order, front cell at index 0.
// Depends on rmt_pkg and rmt_cell.
module rmt_chain
    import rmt_pkg::*;
#(
    parameter int DEPTH       = CAPACITY_DEF / 2 + 1,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter bit DESCEND     = 1'b0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chain_ctrl_t                   ctrl,
    input  logic signed [VALUE_WIDTH-1:0] x,
    output logic signed [VALUE_WIDTH-1:0] front_val,
    output logic                          front_occ
);

    logic signed [VALUE_WIDTH-1:0] cell_val   [DEPTH];
    logic                          cell_occ   [DEPTH];
    logic                          cell_ahead [DEPTH];

    // Build the row; the front cell sees the request value as its neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_WIDTH-1:0] p_val;
        logic                          p_occ;
        logic                          p_ahead;
        logic signed [VALUE_WIDTH-1:0] n_val;
        logic                          n_occ;

        if (i == 0)
        begin : g_head
            assign p_val   = x;
            assign p_occ   = 1'b1;
            assign p_ahead = 1'b1;
        end
        else
        begin : g_body
            assign p_val   = cell_val[i-1];
            assign p_occ   = cell_occ[i-1];
            assign p_ahead = cell_ahead[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign n_val = '0;
            assign n_occ = 1'b0;
        end
        else
        begin : g_inner
            assign n_val = cell_val[i+1];
            assign n_occ = cell_occ[i+1];
        end

        rmt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .DESCEND     (DESCEND)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .x          (x),
            .prev_val   (p_val),
            .prev_occ   (p_occ),
            .prev_ahead (p_ahead),
            .next_val   (n_val),
            .next_occ   (n_occ),
            .val        (cell_val[i]),
            .occ        (cell_occ[i]),
            .ahead      (cell_ahead[i])
        );
    end

    assign front_val = cell_val[0];
    assign front_occ = cell_occ[0];

endmodule
